[hdl/gac_pkg.sv]
// Package for the glyph advance cache: sizes, request codes, state types,
// command structs and the advance function. No dependencies.
`default_nettype none

package gac_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int TICK_BITS    = 32;
	localparam int IDX_BITS     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BIT_IDX_BITS = $clog2(TICK_BITS);
	localparam int CNT_BITS     = 9;
	localparam int WIDTH_BITS   = 24;
	localparam int TOTAL_BITS   = 32;
	localparam int ADV_BITS     = 4;

	localparam logic [1:0] REQ_MEASURE = 2'd0;
	localparam logic [1:0] REQ_COMPACT = 2'd1;
	localparam logic [1:0] REQ_RESET   = 2'd2;

	typedef enum logic [1:0] {
		T_IDLE,
		T_EXEC,
		T_COMPACT
	} top_state_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_SEARCH,
		C_PRUNE
	} cmp_state_t;

	// compact unit -> entry store
	typedef struct packed {
		logic                rd_en;
		logic [IDX_BITS-1:0] rd_addr;
		logic                clr_en;
		logic [IDX_BITS-1:0] clr_addr;
	} cmp_cmd_t;

	// entry store -> compact unit, registered in the cycle after rd_en
	typedef struct packed {
		logic                 valid;
		logic [TICK_BITS-1:0] tick;
	} rd_rsp_t;

	// advance = 6 + code mod 5; quotient by reciprocal 205/1024, exact for 8 bits
	function automatic logic [ADV_BITS-1:0] advance_of(input logic [7:0] code);
		logic [15:0] prod;
		logic [5:0]  quo;
		logic [7:0]  rem;
		prod = 16'(code) * 16'd205;
		quo  = prod[15:10];
		rem  = code - 8'(quo) * 8'd5;
		return ADV_BITS'(4'd6 + 4'(rem[2:0]));
	endfunction

endpackage

`default_nettype wire

[hdl/gac_entry_store.sv]
// Entry store: valid flags in flip-flops and the tick memory with a
// registered read port. Depends on gac_pkg.
`default_nettype none

module gac_entry_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gac_pkg::cmp_cmd_t             cmd,
	output gac_pkg::rd_rsp_t                   rsp,
	input  wire logic                          wr_en,
	input  wire logic [gac_pkg::IDX_BITS-1:0]  wr_addr,
	input  wire logic [gac_pkg::TICK_BITS-1:0] wr_tick,
	input  wire logic                          clr_all,
	input  wire logic [gac_pkg::IDX_BITS-1:0]  look_addr,
	output logic                               look_valid
);

	logic [gac_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [gac_pkg::TICK_BITS-1:0]   tick_mem [gac_pkg::TABLE_DEPTH];

	assign look_valid = valid_q[look_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.clr_en) begin
				valid_q[cmd.clr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tick_mem[wr_addr] <= wr_tick;
		end
		if (cmd.rd_en) begin
			rsp.tick  <= tick_mem[cmd.rd_addr];
			rsp.valid <= valid_q[cmd.rd_addr];
		end
	end

endmodule

`default_nettype wire

[hdl/gac_compact_unit.sv]
// Compaction sequencer: finds the cutoff tick one bit per sweep with one
// shared compare and counter, then drops older entries. Depends on gac_pkg.
`default_nettype none

module gac_compact_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gac_pkg::CNT_BITS-1:0]  n_entries,
	output gac_pkg::cmp_cmd_t                  cmd,
	input  wire gac_pkg::rd_rsp_t              rsp,
	output logic                               done,
	output logic [gac_pkg::CNT_BITS-1:0]       kept
);

	localparam int ADDR_BITS = gac_pkg::IDX_BITS + 1;
	localparam logic [ADDR_BITS-1:0] ADDR_END = ADDR_BITS'(gac_pkg::TABLE_DEPTH);
	localparam logic [gac_pkg::BIT_IDX_BITS-1:0] BIT_TOP =
		gac_pkg::BIT_IDX_BITS'(gac_pkg::TICK_BITS - 1);

	gac_pkg::cmp_state_t                state_q, state_d;
	logic [ADDR_BITS-1:0]               addr_q, addr_d;
	logic [gac_pkg::BIT_IDX_BITS-1:0]   bit_q, bit_d;
	logic [gac_pkg::TICK_BITS-1:0]      cut_q, cut_d;
	logic [gac_pkg::CNT_BITS-1:0]       cnt_q, cnt_d;
	logic [gac_pkg::CNT_BITS-1:0]       k_q, k_d;
	logic                               pend_s1;
	logic [gac_pkg::IDX_BITS-1:0]       addr_s1;

	logic                          issue;
	logic                          pass_end;
	logic [gac_pkg::TICK_BITS-1:0] cand;
	logic [gac_pkg::TICK_BITS-1:0] ref_val;
	logic                          ge;

	assign issue    = (state_q != gac_pkg::C_IDLE) && (addr_q != ADDR_END);
	assign pass_end = (state_q != gac_pkg::C_IDLE) && (addr_q == ADDR_END) && !pend_s1;
	assign cand     = cut_q | ({{(gac_pkg::TICK_BITS-1){1'b0}}, 1'b1} << bit_q);
	assign ref_val  = (state_q == gac_pkg::C_PRUNE) ? cut_q : cand;
	// the one shared comparator
	assign ge       = rsp.valid && (rsp.tick >= ref_val);

	assign cmd.rd_en    = issue;
	assign cmd.rd_addr  = addr_q[gac_pkg::IDX_BITS-1:0];
	assign cmd.clr_en   = (state_q == gac_pkg::C_PRUNE) && pend_s1 && rsp.valid && !ge;
	assign cmd.clr_addr = addr_s1;
	assign kept         = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gac_pkg::C_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		bit_q   <= bit_d;
		cut_q   <= cut_d;
		cnt_q   <= cnt_d;
		k_q     <= k_d;
		addr_s1 <= addr_q[gac_pkg::IDX_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		addr_d  = addr_q;
		bit_d   = bit_q;
		cut_d   = cut_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		done    = 1'b0;
		unique case (state_q)
			gac_pkg::C_IDLE: begin
				if (start) begin
					state_d = gac_pkg::C_SEARCH;
					addr_d  = '0;
					bit_d   = BIT_TOP;
					cut_d   = '0;
					cnt_d   = '0;
					k_d     = n_entries >> 1;
				end
			end
			gac_pkg::C_SEARCH: begin
				if (issue) begin
					addr_d = addr_q + 1'b1;
				end
				if (pend_s1 && ge) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (pass_end) begin
					// keep the bit when enough entries sit at or above it
					if (cnt_q >= k_q) begin
						cut_d = cand;
					end
					addr_d = '0;
					cnt_d  = '0;
					if (bit_q == '0) begin
						state_d = gac_pkg::C_PRUNE;
					end else begin
						bit_d = bit_q - 1'b1;
					end
				end
			end
			gac_pkg::C_PRUNE: begin
				if (issue) begin
					addr_d = addr_q + 1'b1;
				end
				if (pend_s1 && ge) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (pass_end) begin
					done    = 1'b1;
					state_d = gac_pkg::C_IDLE;
				end
			end
			default: begin
				state_d = gac_pkg::C_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hdl/glyph_advance_cache_unit.sv]
// Glyph advance cache top level: request sequencer, counters, running width
// and result register. Depends on gac_pkg, gac_entry_store, gac_compact_unit.
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  req_type, char_code, start_of_text
// result    out        out_valid/out_stall  hit, advance, text_width, hit_total,
//                                           miss_total, entry_count
//
// Measure, reset and no-op requests are accepted, then execute and load the
// result register. Compact with two or more entries adds the bit search:
// TICK_BITS sweeps through the tick memory read port, then one pruning sweep.
// Reset clears every valid flag at once; no clearing pass is needed.
// in_stall is high while a request is in work, and while a finished result is
// held and stalled by the receiver.

module glyph_advance_cache_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      req_type,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            start_of_text,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 hit,
	output logic [gac_pkg::ADV_BITS-1:0]         advance,
	output logic [gac_pkg::WIDTH_BITS-1:0]       text_width,
	output logic [gac_pkg::TOTAL_BITS-1:0]       hit_total,
	output logic [gac_pkg::TOTAL_BITS-1:0]       miss_total,
	output logic [gac_pkg::CNT_BITS-1:0]         entry_count
);

	localparam logic [gac_pkg::TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [gac_pkg::WIDTH_BITS-1:0] WIDTH_MAX = '1;

	// control state
	gac_pkg::top_state_t                 state_q, state_d;
	logic                                out_valid_q;
	logic [gac_pkg::TICK_BITS-1:0]       gtick_q, gtick_d;
	logic [gac_pkg::TOTAL_BITS-1:0]      hits_q, hits_d;
	logic [gac_pkg::TOTAL_BITS-1:0]      misses_q, misses_d;
	logic [gac_pkg::CNT_BITS-1:0]        cached_q, cached_d;
	logic [gac_pkg::WIDTH_BITS-1:0]      wacc_q, wacc_d;

	// captured request
	logic [1:0]                          req_q;
	logic [7:0]                          code_q;
	logic                                start_q;

	// result register
	logic                                res_hit_q;
	logic [gac_pkg::ADV_BITS-1:0]        res_adv_q;

	// execute-stage logic
	logic                                accept;
	logic                                fin;
	logic                                fin_hit;
	logic [gac_pkg::ADV_BITS-1:0]        fin_adv;
	logic                                in_table;
	logic                                look_valid;
	logic                                wr_en;
	logic                                clr_all;
	logic                                cmp_start;
	logic                                cmp_done;
	logic [gac_pkg::CNT_BITS-1:0]        cmp_kept;
	logic [gac_pkg::ADV_BITS-1:0]        adv;
	logic [gac_pkg::WIDTH_BITS:0]        wsum;
	logic [gac_pkg::TICK_BITS-1:0]       tick_inc;
	gac_pkg::cmp_cmd_t                   cmp_cmd;
	gac_pkg::rd_rsp_t                    rd_rsp;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != gac_pkg::T_IDLE) || (out_valid_q && out_stall);

	assign out_valid   = out_valid_q;
	assign hit         = res_hit_q;
	assign advance     = res_adv_q;
	assign text_width  = wacc_q;
	assign hit_total   = hits_q;
	assign miss_total  = misses_q;
	assign entry_count = cached_q;

	assign in_table = {1'b0, code_q} < 9'(gac_pkg::TABLE_DEPTH);
	assign adv      = gac_pkg::advance_of(code_q);
	assign wsum     = {1'b0, wacc_q} + (gac_pkg::WIDTH_BITS+1)'(adv);
	assign tick_inc = gtick_q + 1'b1;

	gac_entry_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmp_cmd),
		.rsp        (rd_rsp),
		.wr_en      (wr_en),
		.wr_addr    (code_q[gac_pkg::IDX_BITS-1:0]),
		.wr_tick    (tick_inc),
		.clr_all    (clr_all),
		.look_addr  (code_q[gac_pkg::IDX_BITS-1:0]),
		.look_valid (look_valid)
	);

	gac_compact_unit u_compact (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmp_start),
		.n_entries (cached_q),
		.cmd       (cmp_cmd),
		.rsp       (rd_rsp),
		.done      (cmp_done),
		.kept      (cmp_kept)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gac_pkg::T_IDLE;
			out_valid_q <= 1'b0;
			gtick_q     <= gac_pkg::TICK_BITS'(1);
			hits_q      <= '0;
			misses_q    <= '0;
			cached_q    <= '0;
			wacc_q      <= '0;
		end else begin
			state_q  <= state_d;
			gtick_q  <= gtick_d;
			hits_q   <= hits_d;
			misses_q <= misses_d;
			cached_q <= cached_d;
			wacc_q   <= wacc_d;
			// a result is only loaded when the register is empty or just drained
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			code_q  <= char_code;
			start_q <= start_of_text;
		end
		if (fin) begin
			res_hit_q <= fin_hit;
			res_adv_q <= fin_adv;
		end
	end

	always_comb begin
		state_d   = state_q;
		gtick_d   = gtick_q;
		hits_d    = hits_q;
		misses_d  = misses_q;
		cached_d  = cached_q;
		wacc_d    = wacc_q;
		fin       = 1'b0;
		fin_hit   = 1'b0;
		fin_adv   = '0;
		wr_en     = 1'b0;
		clr_all   = 1'b0;
		cmp_start = 1'b0;
		unique case (state_q)
			gac_pkg::T_IDLE: begin
				if (accept) begin
					state_d = gac_pkg::T_EXEC;
				end
			end
			gac_pkg::T_EXEC: begin
				priority if (req_q == gac_pkg::REQ_MEASURE && code_q != 8'd0) begin
					fin     = 1'b1;
					state_d = gac_pkg::T_IDLE;
					fin_adv = adv;
					gtick_d = tick_inc;
					if (in_table && look_valid) begin
						// hit: restamp the entry
						fin_hit = 1'b1;
						wr_en   = 1'b1;
						if (hits_q != TOTAL_MAX) begin
							hits_d = hits_q + 1'b1;
						end
					end else begin
						// miss: enter the code when it fits the table
						if (in_table) begin
							wr_en    = 1'b1;
							cached_d = cached_q + 1'b1;
						end
						if (misses_q != TOTAL_MAX) begin
							misses_d = misses_q + 1'b1;
						end
					end
					if (start_q) begin
						wacc_d = gac_pkg::WIDTH_BITS'(adv);
					end else if (wsum[gac_pkg::WIDTH_BITS]) begin
						wacc_d = WIDTH_MAX;
					end else begin
						wacc_d = wsum[gac_pkg::WIDTH_BITS-1:0];
					end
				end else if (req_q == gac_pkg::REQ_COMPACT && cached_q >= 9'd2) begin
					cmp_start = 1'b1;
					state_d   = gac_pkg::T_COMPACT;
				end else if (req_q == gac_pkg::REQ_RESET) begin
					fin      = 1'b1;
					state_d  = gac_pkg::T_IDLE;
					clr_all  = 1'b1;
					gtick_d  = gac_pkg::TICK_BITS'(1);
					hits_d   = '0;
					misses_d = '0;
					cached_d = '0;
				end else begin
					// code zero, small compact or unused request: answer only
					fin     = 1'b1;
					state_d = gac_pkg::T_IDLE;
				end
			end
			gac_pkg::T_COMPACT: begin
				if (cmp_done) begin
					fin      = 1'b1;
					state_d  = gac_pkg::T_IDLE;
					cached_d = cmp_kept;
				end
			end
			default: begin
				state_d = gac_pkg::T_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
